// File: hdl/local_conv_sigmoid_layer_defines.svh
// Assertion macros for the locally connected sigmoid layer.
// Included by the files that carry concurrent checks; depends on nothing.
`ifndef LOCAL_CONV_SIGMOID_LAYER_DEFINES_SVH
`define LOCAL_CONV_SIGMOID_LAYER_DEFINES_SVH

// Check that expr holds in the same cycle as cond.
`define LCSIG_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Check that expr holds in the cycle after cond.
`define LCSIG_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// File: hdl/lcsig_pkg.sv
// Shared types, constants and the sigmoid table builder for the layer.
// No dependencies; the table functions run at elaboration only.
package lcsig_pkg;

  localparam int TAPS = 3;

  typedef logic signed [15:0] q14_t;
  typedef logic signed [31:0] prod_t;

  // Register index decoded from paddr[2]
  localparam logic [0:0] REG_BIAS = 1'b0;

  localparam logic [63:0] Q62_ONE = 64'd1 << 62;

  // (a*b) >> 62 for a, b <= 2^62, from 32-bit partial products
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
    al  = {32'h0, a[31:0]};
    ah  = {32'h0, a[63:32]};
    bl  = {32'h0, b[31:0]};
    bh  = {32'h0, b[63:32]};
    ll  = al * bl;
    lh  = al * bh;
    hl  = ah * bl;
    hh  = ah * bh;
    mid = {32'h0, ll[63:32]} + {32'h0, lh[31:0]} + {32'h0, hl[31:0]};
    lo  = {mid[31:0], ll[31:0]};
    hi  = hh + {32'h0, lh[63:32]} + {32'h0, hl[63:32]} + {32'h0, mid[63:32]};
    return {hi[61:0], 2'b00} | {62'h0, lo[63:62]};
  endfunction

  // Restoring long division by a small divisor
  function automatic logic [63:0] udiv_small(input logic [63:0] num, input logic [5:0] d);
    logic [6:0]  r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[5:0], num[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-16*t) in Q62 for t in [0, 0.5] given in Q62
  function automatic logic [63:0] exp_neg16(input logic [63:0] t);
    logic [63:0] sum, term;
    logic        done;
    sum  = Q62_ONE;
    term = Q62_ONE;
    done = 1'b0;
    for (int n = 1; n < 48; n++) begin
      if (!done) begin
        term = udiv_small(mul_q62(term, t), 6'(n));
        if (term == 64'd0) begin
          done = 1'b1;
        end else if (n[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    for (int i = 0; i < 4; i++) begin
      sum = mul_q62(sum, sum);
    end
    return sum;
  endfunction

  // round(16384 * num / den), tie up
  function automatic logic [15:0] ratio_q14(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] r;
    logic [16:0] q;
    logic [17:0] qr;
    r = num;
    q = '0;
    if (r >= den) begin
      r = r - den;
      q = 17'd1;
    end
    for (int i = 0; i < 15; i++) begin
      r = {r[62:0], 1'b0};
      q = {q[15:0], 1'b0};
      if (r >= den) begin
        r    = r - den;
        q[0] = 1'b1;
      end
    end
    qr = {1'b0, q} + 18'd1;
    return qr[16:1];
  endfunction

  // Sigmoid table entry at the lower edge of entry a
  function automatic logic [14:0] sig_value(input int unsigned a, input int unsigned abits);
    logic [63:0] half, mag, e, den, num;
    logic [15:0] r;
    half = 64'd1 << (abits - 1);
    if (64'(a) < half) begin
      mag = half - 64'(a);
    end else begin
      mag = 64'(a) - half;
    end
    e   = exp_neg16(mag << (62 - abits));
    den = Q62_ONE + e;
    num = (64'(a) < half) ? e : Q62_ONE;
    r   = ratio_q14(num, den);
    return r[14:0];
  endfunction

endpackage

// File: hdl/local_conv_sigmoid_layer.sv
// Locally connected three-tap layer with sigmoid output.
// A result is registered through the product, sum and table stages, in that
// order, after its input transaction is accepted. Throughput: one item per cycle
// while the output is not stalled. A stalled output holds all stages.
// Reset (synchronous, rst high) clears the window, the stage valid bits and
// bias; the sigmoid table is constant and needs no clearing pass.
`include "local_conv_sigmoid_layer_defines.svh"

module local_conv_sigmoid_layer #(
  parameter int SIG_ADDR_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata fields, low bit up: sample, weight_oldest, weight_middle, weight_newest
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic        s_tlast,   // end_of_layer
  // m_tdata fields, low bit up: activation (15 bits), one zero pad bit
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  output logic        m_tlast,   // final_output
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int TAPS = lcsig_pkg::TAPS;

  lcsig_pkg::q14_t  bias;
  lcsig_pkg::q14_t  w  [TAPS];
  lcsig_pkg::q14_t  xc [TAPS];
  logic             vc [TAPS];
  lcsig_pkg::prod_t prod [TAPS];

  logic        adv;
  logic        accept;
  logic        full;
  logic        v1, l1, v2, l2;
  logic [14:0] act;

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == lcsig_pkg::REG_BIAS) ? {16'h0, bias} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bias <= '0;
    end else if (psel && penable && pwrite && paddr[2] == lcsig_pkg::REG_BIAS) begin
      bias <= pwdata[15:0];
    end
  end

  // advance every stage unless a finished result waits
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;

  assign w[0] = s_tdata[31:16];
  assign w[1] = s_tdata[47:32];
  assign w[2] = s_tdata[63:48];

  // cell TAPS-1 takes the new sample; cell j+1 holds window slot j
  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    if (i == TAPS - 1) begin : g_head
      lcsig_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .shift  (accept),
        .clear  (s_tlast),
        .load   (adv),
        .x_in   (s_tdata[15:0]),
        .v_in   (1'b1),
        .weight (w[i]),
        .x      (xc[i]),
        .v      (vc[i]),
        .prod   (prod[i])
      );
    end else begin : g_body
      lcsig_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .shift  (accept),
        .clear  (s_tlast),
        .load   (adv),
        .x_in   (xc[i+1]),
        .v_in   (vc[i+1]),
        .weight (w[i]),
        .x      (xc[i]),
        .v      (vc[i]),
        .prod   (prod[i])
      );
    end
  end

  // oldest window slot valid means the window is full
  assign full = vc[1];

  lcsig_act #(
    .ADDR_BITS (SIG_ADDR_BITS)
  ) u_act (
    .clk  (clk),
    .load (adv),
    .prod (prod),
    .bias (bias),
    .act  (act)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v1       <= accept && full;
      v2       <= v1;
      m_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l1      <= s_tlast;
      l2      <= l1;
      m_tlast <= l2;
    end
  end

  assign m_tdata = {1'b0, act};

  `LCSIG_ASSERT_NEXT(a_layer_clear, clk, rst, accept && s_tlast, !vc[0] && !vc[1] && !vc[2] && xc[0] == 16'sd0 && xc[1] == 16'sd0, "window not cleared after end of layer")
  `LCSIG_ASSERT_NOW(a_fill_order, clk, rst, vc[1], vc[2], "oldest slot valid while middle slot empty")
  `LCSIG_ASSERT_NEXT(a_result_issue, clk, rst, accept && full, v1 && l1 == $past(s_tlast), "full window did not issue a result")

endmodule

// File: hdl/lcsig_cell.sv
// One tap cell of the window chain: holds a sample and its valid bit,
// hands both to the older neighbor, and registers its tap product.
module lcsig_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               shift,
  input  logic               clear,
  input  logic               load,
  input  lcsig_pkg::q14_t    x_in,
  input  logic               v_in,
  input  lcsig_pkg::q14_t    weight,
  output lcsig_pkg::q14_t    x,
  output logic               v,
  output lcsig_pkg::prod_t   prod
);

  always_ff @(posedge clk) begin
    if (rst) begin
      x <= '0;
      v <= 1'b0;
    end else if (shift) begin
      if (clear) begin
        x <= '0;
        v <= 1'b0;
      end else begin
        x <= x_in;
        v <= v_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= 32'(x_in) * 32'(weight);
    end
  end

endmodule

// File: hdl/lcsig_act.sv
// Adds the tap products and bias, saturates, and reads the sigmoid table.
// Depends on lcsig_pkg for the product type and the table builder.
module lcsig_act #(
  parameter int ADDR_BITS = 10
) (
  input  logic               clk,
  input  logic               load,
  input  lcsig_pkg::prod_t   prod [lcsig_pkg::TAPS],
  input  lcsig_pkg::q14_t    bias,
  output logic [14:0]        act
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [14:0]          rom [DEPTH];
  logic signed [33:0]   pre;
  logic [31:0]          sat;
  logic [31:0]          biased;
  logic [ADDR_BITS-1:0] addr;

  for (genvar g = 0; g < DEPTH; g++) begin : g_rom
    localparam logic [14:0] VAL = lcsig_pkg::sig_value(g, ADDR_BITS);
    assign rom[g] = VAL;
  end

  always_comb begin
    pre = 34'(bias) <<< 14;
    for (int i = 0; i < lcsig_pkg::TAPS; i++) begin
      pre = pre + 34'(prod[i]);
    end
    // clamp to [-2^31, 2^31-1]
    if (pre[33:31] == 3'b000 || pre[33:31] == 3'b111) begin
      sat = pre[31:0];
    end else if (pre[33]) begin
      sat = 32'h8000_0000;
    end else begin
      sat = 32'h7FFF_FFFF;
    end
    biased = {~sat[31], sat[30:0]};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      addr <= biased[31 -: ADDR_BITS];
      act  <= rom[addr];
    end
  end

endmodule
